>>> hw/rtl/clx_pkg.sv
// Package for the configuration lexer: token kinds, scan modes, the keyword
// table and the token record passed from the scanner to the result queue.
// No dependencies.
package clx_pkg;

   localparam int KW_COUNT   = 12;
   localparam int KW_MAX_LEN = 20;

   localparam logic [4:0] KIND_IDENT  = 5'd0;
   localparam logic [4:0] KIND_LBRACE = 5'd13;
   localparam logic [4:0] KIND_RBRACE = 5'd14;
   localparam logic [4:0] KIND_SEMI   = 5'd15;
   localparam logic [4:0] KIND_END    = 5'd16;
   localparam logic [4:0] KIND_BAD    = 5'd17;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_SEMI    = 8'h3B;

   localparam logic [19:0] INDEX_MAX  = 20'hFFFFF;
   localparam logic [15:0] LC_MAX     = 16'hFFFF;
   localparam logic [4:0]  LENGTH_MAX = 5'd31;

   // Keywords right-aligned: the first character sits highest.
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      "server", "listen", "root", "index", "location", {"error", "_page"},
      {"allow", "_methods"}, {"auto", "_index"}, {"cgi", "_pass"}, {"cgi", "_extensions"},
      {"upload", "_dir"}, {"client", "_max_body", "_size"}
   };
   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd6, 5'd6, 5'd4, 5'd5, 5'd8, 5'd10, 5'd13, 5'd10, 5'd8, 5'd14, 5'd10, 5'd20
   };

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_IDENT   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [19:0] begin_index;
      logic [19:0] end_index;
      logic [15:0] begin_line;
      logic [15:0] begin_col;
      logic [15:0] end_line;
      logic [15:0] end_col;
      logic [7:0]  bad_byte;
      logic        last;
   } token_type;

   // Per keyword: does byte b sit at position pos of that keyword.
   function automatic logic [KW_COUNT-1:0] kw_hits(input logic [4:0] pos,
                                                   input logic [7:0] b);
      logic [KW_COUNT-1:0] hits;
      logic [4:0]          sh;
      hits = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         sh = KW_LEN[k] - pos - 5'd1;
         if (pos < KW_LEN[k]) begin
            hits[k] = (KW_TEXT[k][{sh, 3'b000} +: 8] == b);
         end
      end
      return hits;
   endfunction

   // Lowest keyword still alive whose length matches wins.
   function automatic logic [4:0] kw_kind(input logic [KW_COUNT-1:0] alive,
                                          input logic [4:0] len);
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive[k] && len == KW_LEN[k]) begin
            kind = 5'(k + 1);
         end
      end
      return kind;
   endfunction

endpackage

>>> hw/rtl/clx_scan.sv
// Scanner for the configuration lexer: position counters, scan mode and
// keyword match bits, plus the tokens one byte produces. Uses clx_pkg.
module clx_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               func,
   input  logic [7:0]         text_byte,
   output clx_pkg::token_type tok0,
   output clx_pkg::token_type tok1,
   output logic [1:0]         tok_count
);
   import clx_pkg::*;

   mode_type            mode_ff, mode_in;
   logic [19:0]         count_ff, count_in;
   logic [15:0]         line_ff, line_in;
   logic [15:0]         col_ff, col_in;
   logic [19:0]         start_index_ff, start_index_in;
   logic [15:0]         start_line_ff, start_line_in;
   logic [15:0]         start_col_ff, start_col_in;
   logic [KW_COUNT-1:0] alive_ff, alive_in;
   logic [4:0]          length_ff, length_in;

   logic                is_space, is_ident, idle_path, single_valid;
   logic [19:0]         adv_count;
   logic [15:0]         adv_line, adv_col;
   logic [4:0]          adv_length;
   token_type           ident_tok, single_tok, end_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         count_ff       <= '0;
         line_ff        <= 16'd1;
         col_ff         <= 16'd1;
         start_index_ff <= '0;
         start_line_ff  <= 16'd1;
         start_col_ff   <= 16'd1;
         alive_ff       <= '1;
         length_ff      <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         count_ff       <= count_in;
         line_ff        <= line_in;
         col_ff         <= col_in;
         start_index_ff <= start_index_in;
         start_line_ff  <= start_line_in;
         start_col_ff   <= start_col_in;
         alive_ff       <= alive_in;
         length_ff      <= length_in;
      end
   end

   always_comb begin
      is_space = (text_byte >= CH_TAB && text_byte <= CH_CR) || text_byte == CH_SPACE;
      is_ident = (text_byte >= 8'h30 && text_byte <= 8'h39) ||
                 (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
                 (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
                 text_byte == 8'h2F || text_byte == 8'h5F || text_byte == 8'h2E ||
                 text_byte == 8'h2D || text_byte == 8'h3A;

      adv_count = (count_ff < INDEX_MAX) ? count_ff + 20'd1 : count_ff;
      if (text_byte == CH_NEWLINE) begin
         adv_line = (line_ff < LC_MAX) ? line_ff + 16'd1 : line_ff;
         adv_col  = 16'd1;
      end else begin
         adv_line = line_ff;
         adv_col  = (col_ff < LC_MAX) ? col_ff + 16'd1 : col_ff;
      end
      adv_length = (length_ff < LENGTH_MAX) ? length_ff + 5'd1 : length_ff;

      ident_tok.kind        = kw_kind(alive_ff, length_ff);
      ident_tok.begin_index = start_index_ff;
      ident_tok.end_index   = count_ff;
      ident_tok.begin_line  = start_line_ff;
      ident_tok.begin_col   = start_col_ff;
      ident_tok.end_line    = line_ff;
      ident_tok.end_col     = col_ff;
      ident_tok.bad_byte    = '0;
      ident_tok.last        = 1'b0;

      end_tok.kind        = KIND_END;
      end_tok.begin_index = count_ff;
      end_tok.end_index   = count_ff;
      end_tok.begin_line  = line_ff;
      end_tok.begin_col   = col_ff;
      end_tok.end_line    = line_ff;
      end_tok.end_col     = col_ff;
      end_tok.bad_byte    = '0;
      end_tok.last        = 1'b1;

      // Single-byte tokens start here and end just past this byte.
      single_tok.kind        = KIND_BAD;
      single_tok.begin_index = count_ff;
      single_tok.end_index   = adv_count;
      single_tok.begin_line  = line_ff;
      single_tok.begin_col   = col_ff;
      single_tok.end_line    = adv_line;
      single_tok.end_col     = adv_col;
      single_tok.bad_byte    = '0;
      single_tok.last        = 1'b1;
      single_valid           = 1'b0;

      mode_in        = mode_ff;
      count_in       = count_ff;
      line_in        = line_ff;
      col_in         = col_ff;
      start_index_in = start_index_ff;
      start_line_in  = start_line_ff;
      start_col_in   = start_col_ff;
      alive_in       = alive_ff;
      length_in      = length_ff;
      tok0           = ident_tok;
      tok1           = end_tok;
      tok_count      = 2'd0;
      idle_path      = 1'b0;

      if (func) begin
         // Close any open identifier, report end, then return to reset state.
         if (mode_ff == MODE_IDENT) begin
            tok_count = 2'd2;
         end else begin
            tok0      = end_tok;
            tok_count = 2'd1;
         end
         mode_in        = MODE_IDLE;
         count_in       = '0;
         line_in        = 16'd1;
         col_in         = 16'd1;
         start_index_in = '0;
         start_line_in  = 16'd1;
         start_col_in   = 16'd1;
         alive_in       = '1;
         length_in      = '0;
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               count_in = adv_count;
               line_in  = adv_line;
               col_in   = adv_col;
               if (text_byte == CH_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_ident) begin
                  alive_in  = alive_ff & kw_hits(length_ff, text_byte);
                  length_in = adv_length;
                  count_in  = adv_count;
                  line_in   = adv_line;
                  col_in    = adv_col;
               end else begin
                  idle_path = 1'b1;
               end
            end
            default: begin
               idle_path = 1'b1;
            end
         endcase

         if (idle_path) begin
            mode_in  = MODE_IDLE;
            count_in = adv_count;
            line_in  = adv_line;
            col_in   = adv_col;
            if (is_space) begin
               single_valid = 1'b0;
            end else if (text_byte == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (text_byte == CH_LBRACE) begin
               single_tok.kind = KIND_LBRACE;
               single_valid    = 1'b1;
            end else if (text_byte == CH_RBRACE) begin
               single_tok.kind = KIND_RBRACE;
               single_valid    = 1'b1;
            end else if (text_byte == CH_SEMI) begin
               single_tok.kind = KIND_SEMI;
               single_valid    = 1'b1;
            end else if (is_ident) begin
               mode_in        = MODE_IDENT;
               start_index_in = count_ff;
               start_line_in  = line_ff;
               start_col_in   = col_ff;
               alive_in       = kw_hits(5'd0, text_byte);
               length_in      = 5'd1;
            end else begin
               single_tok.bad_byte = text_byte;
               single_valid        = 1'b1;
            end

            // An identifier ended by this byte goes out ahead of its token.
            if (mode_ff == MODE_IDENT) begin
               if (single_valid) begin
                  tok1      = single_tok;
                  tok_count = 2'd2;
               end else begin
                  tok0.last = 1'b1;
                  tok_count = 2'd1;
               end
            end else if (single_valid) begin
               tok0      = single_tok;
               tok_count = 2'd1;
            end
         end
      end
   end

endmodule

>>> hw/rtl/config_lexer_with_keywords.sv
// Configuration lexer with keyword recognition, one text byte per word.
// Tokens that a word ends are written into the registered result queue; rsp shows its head.
// Throughput: one word per cycle while req_tready is high; req_tready is low while
// the three-entry result queue holds two or more tokens, as after a two-token word.
// Reset (synchronous) empties the queue and returns to line 1, column 1.
module config_lexer_with_keywords (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] text_byte
   input  logic         req_tuser,   // [0] func: 1 = end of input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // kind, begin_index, end_index, begin_line,
                                     // begin_col, end_line, end_col, bad_byte, pad
   output logic         rsp_tlast
);
   import clx_pkg::*;

   localparam int QUEUE_DEPTH = 3;

   token_type  q_ff [QUEUE_DEPTH];
   token_type  q_in [QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] base;
   logic       req_accept, rsp_accept;
   token_type  tok0, tok1;
   logic [1:0] tok_count;

   assign req_tready = (cnt_ff <= 2'd1);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   clx_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .func      (req_tuser),
      .text_byte (req_tdata),
      .tok0      (tok0),
      .tok1      (tok1),
      .tok_count (tok_count)
   );

   always_comb begin
      q_in = q_ff;
      base = cnt_ff - {1'b0, rsp_accept};
      if (rsp_accept) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      cnt_in = base;
      if (req_accept) begin
         if (tok_count != 2'd0) begin
            q_in[base] = tok0;
         end
         if (tok_count == 2'd2) begin
            q_in[base + 2'd1] = tok1;
         end
         cnt_in = base + tok_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp_tdata = {3'b000, q_ff[0].bad_byte, q_ff[0].end_col, q_ff[0].end_line,
                       q_ff[0].begin_col, q_ff[0].begin_line, q_ff[0].end_index,
                       q_ff[0].begin_index, q_ff[0].kind};
   assign rsp_tlast = q_ff[0].last;

   // End tokens close the word's output and carry an empty span.
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && q_ff[0].kind == KIND_END |-> rsp_tlast &&
      q_ff[0].begin_index == q_ff[0].end_index)
      else $error("end token without last or with non-empty span");

   a_bad_byte_only_bad : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && q_ff[0].kind != KIND_BAD |-> q_ff[0].bad_byte == 8'd0)
      else $error("bad_byte set on a token that is not a bad byte");

   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      req_accept && tok_count == 2'd2 |=> cnt_ff >= 2'd1)
      else $error("two-token word lost a result in the queue");

endmodule
